@@ rtl/core/tcw_pkg.sv @@
// Shared types, constants and codes for the text console writer.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package tcw_pkg;

  // Default screen geometry limits.
  localparam int unsigned DEF_MAX_COLUMNS = 80;
  localparam int unsigned DEF_MAX_LINES   = 25;
  localparam int unsigned DEF_CELL_COUNT  = DEF_MAX_COLUMNS * DEF_MAX_LINES;

  // Field widths of the ports.
  localparam int unsigned OPCODE_W    = 2;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned INDEX_W     = 11;
  localparam int unsigned LINE_W      = 5;
  localparam int unsigned COLUMN_W    = 7;
  localparam int unsigned ADDR_OUT_W  = 11;
  localparam int unsigned CELL_W      = 16;
  localparam int unsigned ATTR_W      = 8;
  localparam int unsigned COLS_CFG_W  = 7;
  localparam int unsigned LINES_CFG_W = 5;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 8;

  // Character codes and reset values.
  localparam logic [CHAR_W-1:0]      NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0]      SPACE_CODE   = 8'h20;
  localparam logic [ATTR_W-1:0]      RESET_ATTR   = 8'h07;
  localparam logic [COLS_CFG_W-1:0]  RESET_COLS   = 7'd80;
  localparam logic [LINES_CFG_W-1:0] RESET_LINES  = 5'd25;
  localparam logic [CELL_W-1:0]      RESET_BLANK  = {RESET_ATTR, SPACE_CODE};

  // Operation codes; code 3 is unused and only reports the cursor.
  typedef enum logic [OPCODE_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } opcode_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTR  = 2'd0,
    REG_COLS  = 2'd1,
    REG_LINES = 2'd2
  } reg_idx_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCROLL,
    ST_CLEAR,
    ST_FINISH
  } state_e;

  // Raw configuration registers as written.
  typedef struct packed {
    logic [ATTR_W-1:0]      attr;
    logic [COLS_CFG_W-1:0]  cols;
    logic [LINES_CFG_W-1:0] lines;
  } cfg_t;

endpackage

`default_nettype wire

@@ rtl/core/text_console_writer.sv @@
// Top level of the text console writer: configuration registers, sequencer and cell store.
// Depends on tcw_pkg, tcw_sequencer and tcw_cell_mem.
//
//  Channel | Direction | Handshake              | Beat contents
//  --------+-----------+------------------------+-----------------------------------------
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//  in      | in        | in_valid_i/in_ready_o   | opcode_i, char_code_i, cell_index_i
//  out     | out       | out_valid_o/out_ready_i | cursor_line_o .. did_scroll_o
//
// A put without a scroll and an unused opcode pass through EXEC and FINISH; a read also
// passes READ. A scroll copies the visible lines up by one and blanks the last line.
// A clear writes every cell.
// After reset the store is swept to blanks while no input beat is taken;
// configuration beats are always taken.
// A finished result waits in the output register; the next input beat is taken meanwhile.
`default_nettype none

module text_console_writer #(
  parameter int unsigned MAX_COLUMNS = tcw_pkg::DEF_MAX_COLUMNS,
  parameter int unsigned MAX_LINES   = tcw_pkg::DEF_MAX_LINES
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [tcw_pkg::OPCODE_W-1:0]    opcode_i,
  input  wire logic [tcw_pkg::CHAR_W-1:0]      char_code_i,
  input  wire logic [tcw_pkg::INDEX_W-1:0]     cell_index_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [tcw_pkg::LINE_W-1:0]           cursor_line_o,
  output logic [tcw_pkg::COLUMN_W-1:0]         cursor_column_o,
  output logic [tcw_pkg::ADDR_OUT_W-1:0]       cursor_address_o,
  output logic [tcw_pkg::CELL_W-1:0]           cell_value_o,
  output logic                                 did_scroll_o
);

  import tcw_pkg::*;

  localparam int unsigned CellCount = MAX_COLUMNS * MAX_LINES;
  localparam int unsigned AddrW     = (CellCount > 1) ? $clog2(CellCount) : 1;

  cfg_t              cfg_q;
  logic              mem_wr_en;
  logic [AddrW-1:0]  mem_wr_addr;
  logic [CELL_W-1:0] mem_wr_data;
  logic              mem_rd_en;
  logic [AddrW-1:0]  mem_rd_addr;
  logic [CELL_W-1:0] mem_rd_data;

  // Configuration registers; writes to an unknown index are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attr  <= RESET_ATTR;
      cfg_q.cols  <= RESET_COLS;
      cfg_q.lines <= RESET_LINES;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ATTR:  cfg_q.attr  <= cfg_data_i[ATTR_W-1:0];
        REG_COLS:  cfg_q.cols  <= cfg_data_i[COLS_CFG_W-1:0];
        REG_LINES: cfg_q.lines <= cfg_data_i[LINES_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Operation sequencer.
  tcw_sequencer #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_LINES   (MAX_LINES)
  ) u_tcw_sequencer (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .char_code_i      (char_code_i),
    .cell_index_i     (cell_index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .cursor_line_o    (cursor_line_o),
    .cursor_column_o  (cursor_column_o),
    .cursor_address_o (cursor_address_o),
    .cell_value_o     (cell_value_o),
    .did_scroll_o     (did_scroll_o),
    .mem_wr_en_o      (mem_wr_en),
    .mem_wr_addr_o    (mem_wr_addr),
    .mem_wr_data_o    (mem_wr_data),
    .mem_rd_en_o      (mem_rd_en),
    .mem_rd_addr_o    (mem_rd_addr),
    .mem_rd_data_i    (mem_rd_data)
  );

  // Character-cell store.
  tcw_cell_mem #(
    .DEPTH  (CellCount),
    .ADDR_W (AddrW),
    .DATA_W (CELL_W)
  ) u_tcw_cell_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

endmodule

`default_nettype wire

@@ rtl/core/tcw_cell_mem.sv @@
// Character-cell store: one write port and one registered read port.
// Depends on tcw_pkg for default sizes only.
`default_nettype none

module tcw_cell_mem #(
  parameter int unsigned DEPTH  = tcw_pkg::DEF_CELL_COUNT,
  parameter int unsigned ADDR_W = $clog2(tcw_pkg::DEF_CELL_COUNT),
  parameter int unsigned DATA_W = tcw_pkg::CELL_W
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [DATA_W-1:0] wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

@@ rtl/core/tcw_sequencer.sv @@
// Operation sequencer: cursor registers, cell store sweeps and the result register.
// Depends on tcw_pkg; drives the ports of tcw_cell_mem.
`default_nettype none

module tcw_sequencer #(
  parameter  int unsigned MAX_COLUMNS = tcw_pkg::DEF_MAX_COLUMNS,
  parameter  int unsigned MAX_LINES   = tcw_pkg::DEF_MAX_LINES,
  localparam int unsigned CellCount   = MAX_COLUMNS * MAX_LINES,
  localparam int unsigned AddrW       = (CellCount > 1) ? $clog2(CellCount) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire tcw_pkg::cfg_t                 cfg_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [tcw_pkg::OPCODE_W-1:0]  opcode_i,
  input  wire logic [tcw_pkg::CHAR_W-1:0]    char_code_i,
  input  wire logic [tcw_pkg::INDEX_W-1:0]   cell_index_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [tcw_pkg::LINE_W-1:0]         cursor_line_o,
  output logic [tcw_pkg::COLUMN_W-1:0]       cursor_column_o,
  output logic [tcw_pkg::ADDR_OUT_W-1:0]     cursor_address_o,
  output logic [tcw_pkg::CELL_W-1:0]         cell_value_o,
  output logic                               did_scroll_o,
  output logic                               mem_wr_en_o,
  output logic [AddrW-1:0]                   mem_wr_addr_o,
  output logic [tcw_pkg::CELL_W-1:0]         mem_wr_data_o,
  output logic                               mem_rd_en_o,
  output logic [AddrW-1:0]                   mem_rd_addr_o,
  input  wire logic [tcw_pkg::CELL_W-1:0]    mem_rd_data_i
);

  import tcw_pkg::*;

  localparam int unsigned ColW = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned RowW = $clog2(MAX_LINES + 1);
  localparam int unsigned MulW = ColW + RowW;
  localparam int unsigned LinW = MulW + 1;
  localparam int unsigned CntW = $clog2(CellCount + 1);

  state_e                state_q, state_d;
  logic [RowW-1:0]       row_q, row_d;
  logic [ColW-1:0]       col_q, col_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  pend_q, pend_d;
  logic [AddrW-1:0]      pend_dst_q, pend_dst_d;
  logic [OPCODE_W-1:0]   op_q;
  logic [CHAR_W-1:0]     char_q;
  logic [INDEX_W-1:0]    idx_q;
  logic [CELL_W-1:0]     cell_q, cell_d;
  logic                  scroll_q, scroll_d;
  logic                  out_valid_q;
  logic [LINE_W-1:0]     out_line_q;
  logic [COLUMN_W-1:0]   out_column_q;
  logic [ADDR_OUT_W-1:0] out_addr_q;
  logic [CELL_W-1:0]     out_cell_q;
  logic                  out_scroll_q;

  logic [ColW-1:0]       cols;
  logic [RowW-1:0]       lines;
  logic [MulW-1:0]       mul;
  logic [LinW-1:0]       lin;
  logic [CELL_W-1:0]     blank;
  logic                  in_range;
  logic                  accept;
  logic                  load_out;
  logic                  is_nl;
  logic [ColW-1:0]       col_a, col_b, put_col;
  logic [RowW-1:0]       row_a, row_b, put_row;
  logic                  wrap;
  logic                  put_scroll;

  // Effective geometry: zero acts as one, values above the limit saturate.
  always_comb begin
    if (cfg_i.cols == '0) begin
      cols = ColW'(1);
    end else if (32'(cfg_i.cols) > MAX_COLUMNS) begin
      cols = ColW'(MAX_COLUMNS);
    end else begin
      cols = ColW'(cfg_i.cols);
    end
    if (cfg_i.lines == '0) begin
      lines = RowW'(1);
    end else if (32'(cfg_i.lines) > MAX_LINES) begin
      lines = RowW'(MAX_LINES);
    end else begin
      lines = RowW'(cfg_i.lines);
    end
  end

  // One shared multiplier: cursor address, and the moved-cell count during a scroll.
  assign mul      = row_q * cols;
  assign lin      = LinW'(col_q) + LinW'(mul);
  assign blank    = {cfg_i.attr, SPACE_CODE};
  assign in_range = 32'(idx_q) < CellCount;
  assign accept   = in_valid_i && (state_q == ST_IDLE);

  // Cursor movement of a put.
  always_comb begin
    is_nl      = (char_q == NEWLINE_CODE);
    col_a      = is_nl ? '0 : col_q + 1'b1;
    row_a      = is_nl ? row_q + 1'b1 : row_q;
    wrap       = (col_a >= cols);
    col_b      = wrap ? '0 : col_a;
    row_b      = wrap ? row_a + 1'b1 : row_a;
    put_scroll = (row_b >= lines);
    put_row    = put_scroll ? lines - 1'b1 : row_b;
    put_col    = put_scroll ? '0 : col_b;
  end

  // Next state, cursor updates and memory accesses.
  always_comb begin
    state_d       = state_q;
    row_d         = row_q;
    col_d         = col_q;
    cnt_d         = cnt_q;
    pend_d        = 1'b0;
    pend_dst_d    = pend_dst_q;
    cell_d        = cell_q;
    scroll_d      = scroll_q;
    in_ready_o    = 1'b0;
    load_out      = 1'b0;
    mem_wr_en_o   = 1'b0;
    mem_wr_addr_o = AddrW'(cnt_q);
    mem_wr_data_o = blank;
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = AddrW'(idx_q);

    // A copy read issued last cycle is written back now.
    if (pend_q) begin
      mem_wr_en_o   = 1'b1;
      mem_wr_addr_o = pend_dst_q;
      mem_wr_data_o = mem_rd_data_i;
    end

    unique case (state_q)
      ST_INIT: begin
        if (32'(cnt_q) < CellCount) begin
          mem_wr_en_o   = 1'b1;
          mem_wr_addr_o = AddrW'(cnt_q);
          mem_wr_data_o = RESET_BLANK;
          cnt_d         = cnt_q + 1'b1;
        end else begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        scroll_d = 1'b0;
        cell_d   = '0;
        unique case (op_q)
          OP_PUT: begin
            // A cursor outside the current geometry writes nothing.
            if (!is_nl && (row_q < lines) && (col_q < cols)) begin
              mem_wr_en_o   = 1'b1;
              mem_wr_addr_o = AddrW'(lin);
              mem_wr_data_o = {cfg_i.attr, char_q};
            end
            row_d    = put_row;
            col_d    = put_col;
            scroll_d = put_scroll;
            cnt_d    = '0;
            state_d  = put_scroll ? ST_SCROLL : ST_FINISH;
          end
          OP_CLEAR: begin
            row_d   = '0;
            col_d   = '0;
            cnt_d   = '0;
            state_d = ST_CLEAR;
          end
          OP_READ: begin
            mem_rd_en_o = in_range;
            state_d     = ST_READ;
          end
          default: begin
            state_d = ST_FINISH;
          end
        endcase
      end
      ST_READ: begin
        if (in_range) begin
          cell_d = mem_rd_data_i;
        end
        state_d = ST_FINISH;
      end
      ST_SCROLL: begin
        // Here the cursor row is the last line, so mul is the moved-cell count.
        // The source leads the destination by a full row, so no forwarding is needed.
        if (LinW'(cnt_q) < LinW'(mul)) begin
          mem_rd_en_o   = 1'b1;
          mem_rd_addr_o = AddrW'(LinW'(cnt_q) + LinW'(cols));
          pend_d        = 1'b1;
          pend_dst_d    = AddrW'(cnt_q);
          cnt_d         = cnt_q + 1'b1;
        end else if (!pend_q) begin
          if (LinW'(cnt_q) < LinW'(mul) + LinW'(cols)) begin
            mem_wr_en_o   = 1'b1;
            mem_wr_addr_o = AddrW'(cnt_q);
            mem_wr_data_o = blank;
            cnt_d         = cnt_q + 1'b1;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_CLEAR: begin
        if (32'(cnt_q) < CellCount) begin
          mem_wr_en_o   = 1'b1;
          mem_wr_addr_o = AddrW'(cnt_q);
          mem_wr_data_o = blank;
          cnt_d         = cnt_q + 1'b1;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      row_q   <= '0;
      col_q   <= '0;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

  // Operation payload and working values.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= opcode_i;
      char_q <= char_code_i;
      idx_q  <= cell_index_i;
    end
    pend_dst_q <= pend_dst_d;
    cell_q     <= cell_d;
    scroll_q   <= scroll_d;
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_line_q   <= LINE_W'(row_q);
      out_column_q <= COLUMN_W'(col_q);
      out_addr_q   <= ADDR_OUT_W'(lin);
      out_cell_q   <= cell_q;
      out_scroll_q <= scroll_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign cursor_line_o    = out_line_q;
  assign cursor_column_o  = out_column_q;
  assign cursor_address_o = out_addr_q;
  assign cell_value_o     = out_cell_q;
  assign did_scroll_o     = out_scroll_q;

endmodule

`default_nettype wire

@@ rtl/core/tcw_checker.sv @@
// Port-level checks for the text console writer, attached by a bind statement.
// Depends on tcw_pkg and on the port list of text_console_writer.
`default_nettype none

module tcw_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_valid_i,
  input wire logic                            in_ready_o,
  input wire logic                            out_valid_o,
  input wire logic                            out_ready_i,
  input wire logic [tcw_pkg::LINE_W-1:0]      cursor_line_o,
  input wire logic [tcw_pkg::COLUMN_W-1:0]    cursor_column_o,
  input wire logic [tcw_pkg::ADDR_OUT_W-1:0]  cursor_address_o,
  input wire logic [tcw_pkg::CELL_W-1:0]      cell_value_o,
  input wire logic                            did_scroll_o
);

  import tcw_pkg::*;

  // A result beat stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped before it was taken");

  // A stalled result beat keeps its address, cell value and scroll flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(cursor_address_o) && $stable(cell_value_o) && $stable(did_scroll_o))
    else $error("stalled result payload changed");

  // One operation at a time: an accepted beat closes the input for the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an operation is in flight");

  // A scroll always leaves the cursor at the start of a line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && did_scroll_o |-> cursor_column_o == '0)
    else $error("scroll left the cursor off column zero");

  // On the top line the linear address equals the column.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (cursor_line_o == '0) |->
      cursor_address_o == ADDR_OUT_W'(cursor_column_o))
    else $error("cursor address does not match the column on the top line");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);

`default_nettype wire
